// ===== rtl/core/gbpa_pkg.sv =====
// Package for the GPU buffer pool allocator.
// Holds field widths, reset values, codes and the structs shared by the core modules.
// No dependencies.
package gbpa_pkg;

   // Field widths.
   localparam int REQ_W    = 3;
   localparam int HANDLE_W = 6;
   localparam int SIZE_W   = 32;
   localparam int ADDR_W   = 48;
   localparam int BYTES_W  = 25;
   localparam int STATUS_W = 3;
   localparam int POOL_W   = 2;
   localparam int SLOT_W   = 4;
   localparam int CSR_IDX_W = 3;

   // Slot value that marks the end of a pool free list.
   localparam logic [SLOT_W-1:0] SLOT_END = '1;

   // Default sizes of the handle table and the pools.
   localparam int DEF_NUM_HANDLES   = 32;
   localparam int DEF_SCANOUT_SLOTS = 4;
   localparam int DEF_GENERAL_SLOTS = 8;
   localparam int DEF_CMD_SLOTS     = 8;

   // Reset values of the slot capacity registers.
   localparam logic [BYTES_W-1:0] RST_SCANOUT_BYTES = 25'd4194304;
   localparam logic [BYTES_W-1:0] RST_GENERAL_BYTES = 25'd524288;
   localparam logic [BYTES_W-1:0] RST_CMD_BYTES     = 25'd65536;

   typedef enum logic [REQ_W-1:0] {
      OP_ALLOC = 3'd0,
      OP_FREE  = 3'd1,
      OP_MAP   = 3'd2,
      OP_UNMAP = 3'd3,
      OP_FLUSH = 3'd4
   } req_op_type;

   typedef enum logic [STATUS_W-1:0] {
      STS_OK       = 3'd0,
      STS_INVALID  = 3'd1,
      STS_PINNED   = 3'd2,
      STS_NO_SPACE = 3'd3,
      STS_BAD      = 3'd4
   } status_type;

   typedef enum logic [POOL_W-1:0] {
      POOL_NONE    = 2'd0,
      POOL_SCANOUT = 2'd1,
      POOL_GENERAL = 2'd2,
      POOL_COMMAND = 2'd3
   } pool_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SCANOUT_BASE  = 3'd0,
      CSR_GENERAL_BASE  = 3'd1,
      CSR_CMD_BASE      = 3'd2,
      CSR_SCANOUT_BYTES = 3'd3,
      CSR_GENERAL_BYTES = 3'd4,
      CSR_CMD_BYTES     = 3'd5
   } csr_index_type;

   typedef enum logic {
      FSM_IDLE = 1'b0,
      FSM_EXEC = 1'b1
   } fsm_state_type;

   // Configuration registers as seen by the datapath.
   typedef struct packed {
      logic [ADDR_W-1:0]  scanout_base;
      logic [ADDR_W-1:0]  general_base;
      logic [ADDR_W-1:0]  cmd_base;
      logic [BYTES_W-1:0] scanout_bytes;
      logic [BYTES_W-1:0] general_bytes;
      logic [BYTES_W-1:0] cmd_bytes;
   } cfg_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic execute;
   } ctrl_cmd_type;

   // Commands to one pool free list.
   typedef struct packed {
      logic              pop;
      logic              push;
      logic [SLOT_W-1:0] slot;
   } slot_cmd_type;

   // Per-handle backing slot record.
   typedef struct packed {
      pool_type          pool;
      logic [SLOT_W-1:0] slot;
   } entry_type;

endpackage

// ===== rtl/core/gbpa_csr.sv =====
// Configuration registers of the GPU buffer pool allocator.
// Depends on gbpa_pkg for widths, register indexes and reset values.
module gbpa_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [gbpa_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [gbpa_pkg::ADDR_W-1:0]    csr_wr_data,
   output gbpa_pkg::cfg_type              cfg
);
   import gbpa_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Decode a write into the addressed register; unknown indexes are dropped.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_SCANOUT_BASE:  cfg_in.scanout_base  = csr_wr_data;
            CSR_GENERAL_BASE:  cfg_in.general_base  = csr_wr_data;
            CSR_CMD_BASE:      cfg_in.cmd_base      = csr_wr_data;
            CSR_SCANOUT_BYTES: cfg_in.scanout_bytes = csr_wr_data[BYTES_W-1:0];
            CSR_GENERAL_BYTES: cfg_in.general_bytes = csr_wr_data[BYTES_W-1:0];
            CSR_CMD_BYTES:     cfg_in.cmd_bytes     = csr_wr_data[BYTES_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.scanout_base  <= '0;
         cfg_ff.general_base  <= '0;
         cfg_ff.cmd_base      <= '0;
         cfg_ff.scanout_bytes <= RST_SCANOUT_BYTES;
         cfg_ff.general_bytes <= RST_GENERAL_BYTES;
         cfg_ff.cmd_bytes     <= RST_CMD_BYTES;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/core/gbpa_slot_list.sv =====
// LIFO free list of slot indexes for one size-class pool.
// Depends on gbpa_pkg for the slot width, end mark and command struct.
module gbpa_slot_list #(
   parameter int DEPTH = gbpa_pkg::DEF_GENERAL_SLOTS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  gbpa_pkg::slot_cmd_type      cmd,
   output logic [gbpa_pkg::SLOT_W-1:0] top_slot,
   output logic                        empty
);
   import gbpa_pkg::*;

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [SLOT_W-1:0] DEPTH_V = SLOT_W'(DEPTH);

   logic [SLOT_W-1:0] link_ff [DEPTH];
   logic [SLOT_W-1:0] top_ff;
   logic [SLOT_W-1:0] top_in;

   // A push puts the freed slot on top; a pop follows the link of the top slot.
   always_comb begin
      top_in = top_ff;
      priority if (cmd.push) begin
         top_in = cmd.slot;
      end else if (cmd.pop) begin
         top_in = link_ff[top_ff[IDX_W-1:0]];
      end else begin
         top_in = top_ff;
      end
   end

   // The list starts as every slot in ascending order.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) begin
            link_ff[i] <= (i + 1 < DEPTH) ? SLOT_W'(i + 1) : SLOT_END;
         end
         top_ff <= '0;
      end else begin
         top_ff <= top_in;
         if (cmd.push) begin
            link_ff[cmd.slot[IDX_W-1:0]] <= top_ff;
         end
      end
   end

   assign top_slot = top_ff;
   assign empty    = (top_ff >= DEPTH_V);

`ifndef SYNTH
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.pop |-> !empty)
      else $error("Slot list popped while empty.");

   a_push_pop_excl: assert property (@(posedge clock) disable iff (reset)
      !(cmd.pop && cmd.push))
      else $error("Slot list pushed and popped in one cycle.");
`endif

endmodule

// ===== rtl/core/gbpa_datapath.sv =====
// Datapath of the GPU buffer pool allocator: request latch, handle table,
// handle free list, pool free lists, address unit and result register.
// Depends on gbpa_pkg and gbpa_slot_list.
module gbpa_datapath #(
   parameter int NUM_HANDLES   = gbpa_pkg::DEF_NUM_HANDLES,
   parameter int SCANOUT_SLOTS = gbpa_pkg::DEF_SCANOUT_SLOTS,
   parameter int GENERAL_SLOTS = gbpa_pkg::DEF_GENERAL_SLOTS,
   parameter int CMD_SLOTS     = gbpa_pkg::DEF_CMD_SLOTS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  gbpa_pkg::ctrl_cmd_type        cmd,
   input  gbpa_pkg::cfg_type             cfg,
   input  logic [gbpa_pkg::REQ_W-1:0]    req_type,
   input  logic [gbpa_pkg::HANDLE_W-1:0] req_handle,
   input  logic [gbpa_pkg::SIZE_W-1:0]   req_size,
   input  logic                          req_want_scanout,
   input  logic                          req_want_uniform_or_shader,
   input  logic                          req_want_pinned,
   output logic [gbpa_pkg::STATUS_W-1:0] rsp_status,
   output logic [gbpa_pkg::HANDLE_W-1:0] rsp_out_handle,
   output logic [gbpa_pkg::ADDR_W-1:0]   rsp_address,
   output logic [gbpa_pkg::POOL_W-1:0]   rsp_pool_used
);
   import gbpa_pkg::*;

   localparam int HIDX_W = (NUM_HANDLES > 1) ? $clog2(NUM_HANDLES) : 1;
   localparam int HL_W   = $clog2(NUM_HANDLES + 1);
   localparam int HCMP_W = HANDLE_W + 1;
   localparam int PROD_W = SLOT_W + BYTES_W;
   localparam logic [HL_W-1:0]   HANDLE_END = HL_W'(NUM_HANDLES);
   localparam logic [SLOT_W-1:0] SCAN_DEPTH = SLOT_W'(SCANOUT_SLOTS);
   localparam logic [SLOT_W-1:0] GEN_DEPTH  = SLOT_W'(GENERAL_SLOTS);
   localparam logic [SLOT_W-1:0] CMD_DEPTH  = SLOT_W'(CMD_SLOTS);

   // Latched request.
   logic [REQ_W-1:0]    op_ff;
   logic [HANDLE_W-1:0] handle_ff;
   logic [SIZE_W-1:0]   size_ff;
   logic                scan_ff;
   logic                us_ff;
   logic                pin_ff;

   // Handle table flags and the head of the handle free list.
   logic [NUM_HANDLES-1:0] valid_ff;
   logic [NUM_HANDLES-1:0] mapped_ff;
   logic [NUM_HANDLES-1:0] dirty_ff;
   logic [NUM_HANDLES-1:0] pinned_ff;
   logic [HL_W-1:0]        handle_top_ff;
   logic [HL_W-1:0]        handle_top_in;

   // Backing slot memory and handle link memory.
   entry_type              entry_mem [NUM_HANDLES];
   entry_type              entry_rd_ff;
   logic [HIDX_W-1:0]      entry_raddr;
   logic [HL_W-1:0]        link_mem [NUM_HANDLES];
   logic [NUM_HANDLES-1:0] link_known_ff;
   logic [HL_W-1:0]        link_rd_ff;
   logic                   link_known_rd_ff;
   logic [HIDX_W-1:0]      link_raddr;
   logic [HIDX_W-1:0]      link_raddr_ff;
   logic [HL_W-1:0]        link_next;

   // Decode of the latched request.
   logic [HIDX_W-1:0]   idx;
   logic [HIDX_W-1:0]   alloc_idx;
   logic                hok;
   logic                handles_empty;
   logic                cmd_fit;
   logic                gen_fit;
   pool_type            alloc_kind;
   logic                kind_empty;
   logic [SLOT_W-1:0]   kind_top;
   pool_type            ent_pool;
   logic [SLOT_W-1:0]   ent_slot;
   logic                ent_ok;
   logic [ADDR_W-1:0]   sel_base;
   logic [BYTES_W-1:0]  sel_cap;
   logic [PROD_W-1:0]   prod;
   logic [ADDR_W-1:0]   map_addr;
   logic [HL_W:0]       new_handle;

   // Decision and result.
   status_type          status_c;
   logic [HANDLE_W-1:0] handle_c;
   logic [ADDR_W-1:0]   addr_c;
   pool_type            pused_c;
   logic                alloc_ok;
   logic                free_ok;
   logic                map_ok;
   logic                unmap_ok;
   logic                flush_ok;

   // Pool lists.
   slot_cmd_type        scan_cmd;
   slot_cmd_type        gen_cmd;
   slot_cmd_type        cmdp_cmd;
   logic [SLOT_W-1:0]   scan_top;
   logic [SLOT_W-1:0]   gen_top;
   logic [SLOT_W-1:0]   cmdp_top;
   logic                scan_empty;
   logic                gen_empty;
   logic                cmdp_empty;

   // Result register.
   status_type          status_ff;
   logic [HANDLE_W-1:0] out_handle_ff;
   logic [ADDR_W-1:0]   address_ff;
   pool_type            pused_ff;

   // Latch the request on its transfer.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff     <= req_type;
         handle_ff <= req_handle;
         size_ff   <= req_size;
         scan_ff   <= req_want_scanout;
         us_ff     <= req_want_uniform_or_shader;
         pin_ff    <= req_want_pinned;
      end
   end

   // Backing slot memory: read at the incoming handle, written on alloc.
   assign entry_raddr = HIDX_W'(req_handle - HANDLE_W'(1));

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         entry_rd_ff <= entry_mem[entry_raddr];
      end
      if (cmd.execute && alloc_ok) begin
         entry_mem[alloc_idx] <= '{pool: alloc_kind, slot: kind_top};
      end
   end

   // Handle link memory: read every cycle at the list head, written on free.
   // Entries never written read as their ascending reset link.
   assign link_raddr = HIDX_W'(handle_top_ff);

   always_ff @(posedge clock) begin
      link_rd_ff       <= link_mem[link_raddr];
      link_known_rd_ff <= link_known_ff[link_raddr];
      link_raddr_ff    <= link_raddr;
      if (cmd.execute && free_ok) begin
         link_mem[idx] <= handle_top_ff;
      end
   end

   assign link_next = link_known_rd_ff ? link_rd_ff : (HL_W'(link_raddr_ff) + HL_W'(1));

   // Handle checks.
   assign idx           = HIDX_W'(handle_ff - HANDLE_W'(1));
   assign alloc_idx     = HIDX_W'(handle_top_ff);
   assign hok           = (handle_ff != '0) && (HCMP_W'(handle_ff) <= HCMP_W'(NUM_HANDLES))
                          && valid_ff[idx];
   assign handles_empty = (handle_top_ff >= HANDLE_END);
   assign new_handle    = (HL_W + 1)'(handle_top_ff) + (HL_W + 1)'(1);

   // Pool choice for alloc from the type flags and the size.
   assign cmd_fit = (size_ff <= SIZE_W'(cfg.cmd_bytes));
   assign gen_fit = (size_ff <= SIZE_W'(cfg.general_bytes));

   always_comb begin
      priority if (size_ff == '0) begin
         alloc_kind = POOL_NONE;
      end else if (scan_ff) begin
         alloc_kind = POOL_SCANOUT;
      end else if (us_ff && cmd_fit) begin
         alloc_kind = POOL_COMMAND;
      end else if (gen_fit) begin
         alloc_kind = POOL_GENERAL;
      end else if (cmd_fit) begin
         alloc_kind = POOL_COMMAND;
      end else begin
         alloc_kind = POOL_NONE;
      end
   end

   // State of the chosen pool.
   always_comb begin
      unique case (alloc_kind)
         POOL_SCANOUT: begin
            kind_empty = scan_empty;
            kind_top   = scan_top;
         end
         POOL_GENERAL: begin
            kind_empty = gen_empty;
            kind_top   = gen_top;
         end
         POOL_COMMAND: begin
            kind_empty = cmdp_empty;
            kind_top   = cmdp_top;
         end
         default: begin
            kind_empty = 1'b1;
            kind_top   = SLOT_END;
         end
      endcase
   end

   // Backing slot of the addressed handle, its range check and its address.
   assign ent_pool = entry_rd_ff.pool;
   assign ent_slot = entry_rd_ff.slot;

   always_comb begin
      unique case (ent_pool)
         POOL_SCANOUT: begin
            ent_ok   = (ent_slot < SCAN_DEPTH);
            sel_base = cfg.scanout_base;
            sel_cap  = cfg.scanout_bytes;
         end
         POOL_GENERAL: begin
            ent_ok   = (ent_slot < GEN_DEPTH);
            sel_base = cfg.general_base;
            sel_cap  = cfg.general_bytes;
         end
         POOL_COMMAND: begin
            ent_ok   = (ent_slot < CMD_DEPTH);
            sel_base = cfg.cmd_base;
            sel_cap  = cfg.cmd_bytes;
         end
         default: begin
            ent_ok   = 1'b0;
            sel_base = cfg.cmd_base;
            sel_cap  = cfg.cmd_bytes;
         end
      endcase
   end

   assign prod     = PROD_W'(ent_slot) * PROD_W'(sel_cap);
   assign map_addr = sel_base + ADDR_W'(prod);

   // Request decision.
   always_comb begin
      status_c = STS_OK;
      handle_c = '0;
      addr_c   = '0;
      pused_c  = POOL_NONE;
      alloc_ok = 1'b0;
      free_ok  = 1'b0;
      map_ok   = 1'b0;
      unmap_ok = 1'b0;
      flush_ok = 1'b0;
      unique case (op_ff)
         OP_ALLOC: begin
            if (alloc_kind == POOL_NONE) begin
               status_c = STS_BAD;
            end else if (handles_empty || kind_empty) begin
               status_c = STS_NO_SPACE;
            end else begin
               alloc_ok = 1'b1;
               handle_c = HANDLE_W'(new_handle);
               pused_c  = alloc_kind;
            end
         end
         OP_FREE: begin
            if (!hok) begin
               status_c = STS_INVALID;
            end else if (pinned_ff[idx]) begin
               status_c = STS_PINNED;
            end else if (!ent_ok) begin
               status_c = STS_INVALID;
            end else begin
               free_ok = 1'b1;
               pused_c = ent_pool;
            end
         end
         OP_MAP: begin
            if (!hok) begin
               status_c = STS_INVALID;
            end else begin
               map_ok = 1'b1;
               if (ent_ok) begin
                  addr_c  = map_addr;
                  pused_c = ent_pool;
               end
            end
         end
         OP_UNMAP: begin
            if (!hok) begin
               status_c = STS_INVALID;
            end else if (!mapped_ff[idx]) begin
               status_c = STS_BAD;
            end else begin
               unmap_ok = 1'b1;
               pused_c  = ent_pool;
            end
         end
         OP_FLUSH: begin
            flush_ok = 1'b1;
         end
         default: begin
            status_c = STS_BAD;
         end
      endcase
   end

   // Pool list commands: alloc pops the chosen pool, free pushes the slot back.
   always_comb begin
      scan_cmd.pop  = cmd.execute && alloc_ok && (alloc_kind == POOL_SCANOUT);
      scan_cmd.push = cmd.execute && free_ok && (ent_pool == POOL_SCANOUT);
      scan_cmd.slot = ent_slot;
      gen_cmd.pop   = cmd.execute && alloc_ok && (alloc_kind == POOL_GENERAL);
      gen_cmd.push  = cmd.execute && free_ok && (ent_pool == POOL_GENERAL);
      gen_cmd.slot  = ent_slot;
      cmdp_cmd.pop  = cmd.execute && alloc_ok && (alloc_kind == POOL_COMMAND);
      cmdp_cmd.push = cmd.execute && free_ok && (ent_pool == POOL_COMMAND);
      cmdp_cmd.slot = ent_slot;
   end

   gbpa_slot_list #(.DEPTH(SCANOUT_SLOTS)) u_scan_list (
      .clock    (clock),
      .reset    (reset),
      .cmd      (scan_cmd),
      .top_slot (scan_top),
      .empty    (scan_empty)
   );

   gbpa_slot_list #(.DEPTH(GENERAL_SLOTS)) u_gen_list (
      .clock    (clock),
      .reset    (reset),
      .cmd      (gen_cmd),
      .top_slot (gen_top),
      .empty    (gen_empty)
   );

   gbpa_slot_list #(.DEPTH(CMD_SLOTS)) u_cmd_list (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmdp_cmd),
      .top_slot (cmdp_top),
      .empty    (cmdp_empty)
   );

   // Head of the handle free list.
   always_comb begin
      handle_top_in = handle_top_ff;
      if (cmd.execute && alloc_ok) begin
         handle_top_in = link_next;
      end else if (cmd.execute && free_ok) begin
         handle_top_in = HL_W'(idx);
      end
   end

   // Handle table flag updates.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         mapped_ff     <= '0;
         dirty_ff      <= '0;
         pinned_ff     <= '0;
         link_known_ff <= '0;
         handle_top_ff <= '0;
      end else begin
         handle_top_ff <= handle_top_in;
         if (cmd.execute) begin
            if (alloc_ok) begin
               valid_ff[alloc_idx]  <= 1'b1;
               mapped_ff[alloc_idx] <= 1'b0;
               dirty_ff[alloc_idx]  <= 1'b1;
               pinned_ff[alloc_idx] <= pin_ff;
            end
            if (free_ok) begin
               valid_ff[idx]      <= 1'b0;
               mapped_ff[idx]     <= 1'b0;
               dirty_ff[idx]      <= 1'b0;
               pinned_ff[idx]     <= 1'b0;
               link_known_ff[idx] <= 1'b1;
            end
            if (map_ok) begin
               mapped_ff[idx] <= 1'b1;
               dirty_ff[idx]  <= 1'b1;
            end
            if (unmap_ok) begin
               mapped_ff[idx] <= 1'b0;
               dirty_ff[idx]  <= 1'b0;
            end
            if (flush_ok) begin
               dirty_ff <= '0;
            end
         end
      end
   end

   // Result register, loaded when the request executes.
   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         status_ff     <= status_c;
         out_handle_ff <= handle_c;
         address_ff    <= addr_c;
         pused_ff      <= pused_c;
      end
   end

   assign rsp_status     = status_ff;
   assign rsp_out_handle = out_handle_ff;
   assign rsp_address    = address_ff;
   assign rsp_pool_used  = pused_ff;

`ifndef SYNTH
   a_alloc_free_entry: assert property (@(posedge clock) disable iff (reset)
      (cmd.execute && alloc_ok) |-> !valid_ff[alloc_idx])
      else $error("Handle free list handed out an entry that is in use.");

   a_handle_top_range: assert property (@(posedge clock) disable iff (reset)
      handle_top_ff <= HANDLE_END)
      else $error("Handle free list head out of range.");
`endif

endmodule

// ===== rtl/core/gbpa_ctrl.sv =====
// Controller of the GPU buffer pool allocator: request sequencing and result handshake.
// Depends on gbpa_pkg for the state and command types.
module gbpa_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output gbpa_pkg::ctrl_cmd_type cmd
);
   import gbpa_pkg::*;

   fsm_state_type state_ff;
   fsm_state_type state_in;
   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   logic          out_free;

   // The result register can take a new result once the old one is transferred.
   assign out_free = !rsp_valid_ff || rsp_ready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FSM_IDLE: begin
            if (req_valid) begin
               state_in = FSM_EXEC;
            end
         end
         FSM_EXEC: begin
            if (out_free) begin
               state_in = FSM_IDLE;
            end
         end
      endcase
   end

   // Outputs.
   always_comb begin
      req_ready   = 1'b0;
      cmd.capture = 1'b0;
      cmd.execute = 1'b0;
      unique case (state_ff)
         FSM_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         FSM_EXEC: begin
            cmd.execute = out_free;
         end
      endcase
   end

   // Result valid flag.
   assign rsp_valid_in = cmd.execute || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTH
   a_exec_shows_result: assert property (@(posedge clock) disable iff (reset)
      cmd.execute |=> rsp_valid)
      else $error("Executed request produced no result.");
`endif

endmodule

// ===== rtl/core/gpu_buffer_pool_allocator.sv =====
// Top level of the GPU buffer pool allocator.
// Depends on gbpa_pkg, gbpa_csr, gbpa_ctrl, gbpa_datapath and gbpa_slot_list.
//
// Allocates buffer handles from a LIFO handle free list, each backed by a slot taken from
// the scanout, general or command pool, and serves free, map, unmap and flush requests
// with one result per request. A request is latched in IDLE and executed in EXEC; no new
// request is taken until it has executed. The handle link and slot record memories have
// registered reads, which sets this latch-then-execute order. The result waits in
// an output register, and the next request may be taken while it waits; execution of that
// request holds until the previous result is transferred. There is no clearing pass after
// reset: the handle table is ready when reset ends. Configuration registers are written
// through the csr_ port and should be changed only while no request is outstanding.
module gpu_buffer_pool_allocator #(
   parameter int NUM_HANDLES   = gbpa_pkg::DEF_NUM_HANDLES,
   parameter int SCANOUT_SLOTS = gbpa_pkg::DEF_SCANOUT_SLOTS,
   parameter int GENERAL_SLOTS = gbpa_pkg::DEF_GENERAL_SLOTS,
   parameter int CMD_SLOTS     = gbpa_pkg::DEF_CMD_SLOTS
) (
   input  logic                           clock,
   input  logic                           reset,
   // Configuration write port.
   input  logic                           csr_wr_en,
   input  logic [gbpa_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [gbpa_pkg::ADDR_W-1:0]    csr_wr_data,
   // Request channel.
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [gbpa_pkg::REQ_W-1:0]     req_type,
   input  logic [gbpa_pkg::HANDLE_W-1:0]  req_handle,
   input  logic [gbpa_pkg::SIZE_W-1:0]    req_size,
   input  logic                           req_want_scanout,
   input  logic                           req_want_uniform_or_shader,
   input  logic                           req_want_pinned,
   // Result channel.
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [gbpa_pkg::STATUS_W-1:0]  rsp_status,
   output logic [gbpa_pkg::HANDLE_W-1:0]  rsp_out_handle,
   output logic [gbpa_pkg::ADDR_W-1:0]    rsp_address,
   output logic [gbpa_pkg::POOL_W-1:0]    rsp_pool_used
);
   import gbpa_pkg::*;

   cfg_type      cfg;
   ctrl_cmd_type cmd;

   // Configuration registers.
   gbpa_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .cfg         (cfg)
   );

   // Request sequencing.
   gbpa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   // Allocator state and result computation.
   gbpa_datapath #(
      .NUM_HANDLES   (NUM_HANDLES),
      .SCANOUT_SLOTS (SCANOUT_SLOTS),
      .GENERAL_SLOTS (GENERAL_SLOTS),
      .CMD_SLOTS     (CMD_SLOTS)
   ) u_datapath (
      .clock                      (clock),
      .reset                      (reset),
      .cmd                        (cmd),
      .cfg                        (cfg),
      .req_type                   (req_type),
      .req_handle                 (req_handle),
      .req_size                   (req_size),
      .req_want_scanout           (req_want_scanout),
      .req_want_uniform_or_shader (req_want_uniform_or_shader),
      .req_want_pinned            (req_want_pinned),
      .rsp_status                 (rsp_status),
      .rsp_out_handle             (rsp_out_handle),
      .rsp_address                (rsp_address),
      .rsp_pool_used              (rsp_pool_used)
   );

endmodule
